// ===== rtl/tbc_pkg.sv =====
// Package for the text buffer with cursor: request codes, status codes,
// controller states, memory control struct and the whitespace test.
// No dependencies.
package tbc_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_FWD,
    REQ_BACK,
    REQ_START,
    REQ_END,
    REQ_INSERT,
    REQ_DELETE,
    REQ_WORD,
    REQ_READ
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE,
    STAT_NOCHG,
    STAT_FULL
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_RDAT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Tab, line feed, vertical tab, form feed, carriage return and space
  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

endpackage

// ===== rtl/tbc_mem.sv =====
// Character store of the gap buffer: one write port, one read port,
// registered read data. Uses tbc_pkg for the control struct.
module tbc_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  tbc_pkg::mem_ctl_t             ctl_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [tbc_pkg::CHAR_W-1:0]    wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [tbc_pkg::CHAR_W-1:0]    rdata_o
);
  import tbc_pkg::*;

  logic [CHAR_W-1:0] mem_q [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tbc_ctrl.sv =====
// Request sequencer of the gap buffer: cursor and length registers,
// gap moves one character per cycle, store access control.
// Uses tbc_pkg; drives tbc_mem.
module tbc_ctrl #(
  parameter int unsigned MAX_CHARS = 1024,
  localparam int unsigned AW = $clog2(MAX_CHARS),
  localparam int unsigned CW = $clog2(MAX_CHARS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbc_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tbc_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [tbc_pkg::IDX_W-1:0]     read_index_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output tbc_pkg::stat_e                res_status_o,
  output logic [CW-1:0]                 res_cursor_o,
  output logic [CW-1:0]                 res_length_o,
  output logic [tbc_pkg::CHAR_W-1:0]    res_char_o,
  output tbc_pkg::mem_ctl_t             mem_ctl_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [tbc_pkg::CHAR_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [tbc_pkg::CHAR_W-1:0]    mem_rdata_i
);
  import tbc_pkg::*;

  localparam int unsigned IW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_CHARS);

  state_e            state_q, state_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     len_q, len_d;
  req_e              req_q;
  logic [CHAR_W-1:0] ch_q;
  logic [IDX_W-1:0]  idx_q;
  stat_e             stat_q, stat_d;
  logic [CHAR_W-1:0] rd_q, rd_d;
  logic              first_q, first_d;

  logic              accept;
  logic [CW-1:0]     gap;
  logic              is_back;
  logic              step_move;
  logic [CW-1:0]     cur_step;
  logic              step_more;
  logic [IW-1:0]     idx_w;
  logic              idx_ok;
  logic [AW-1:0]     rd_phys;
  logic [CW-1:0]     rd_base;
  logic              exec_move;

  assign accept = in_valid_i && in_ready_o;
  assign gap    = MaxCnt - len_q;

  // Gap move direction and the decision taken on the character just read
  assign is_back   = (req_q != REQ_FWD) && (req_q != REQ_END);
  assign step_move = (req_q != REQ_WORD) || first_q || !is_blank(mem_rdata_i);
  always_comb begin
    cur_step = cur_q;
    if (step_move) begin
      cur_step = is_back ? (cur_q - 1'b1) : (cur_q + 1'b1);
    end
  end

  always_comb begin
    case (req_q)
      REQ_START: step_more = (cur_step != '0);
      REQ_END:   step_more = (cur_step != len_q);
      REQ_WORD:  step_more = step_move && (cur_step != '0);
      default:   step_more = 1'b0;
    endcase
  end

  // Does the request need a gap move at all
  always_comb begin
    case (req_q)
      REQ_FWD:   exec_move = (cur_q < len_q);
      REQ_END:   exec_move = (cur_q != len_q);
      REQ_BACK,
      REQ_START,
      REQ_WORD:  exec_move = (cur_q != '0);
      default:   exec_move = 1'b0;
    endcase
  end

  // Map a logical read index onto the store
  assign idx_w   = IW'(idx_q);
  assign idx_ok  = idx_w < IW'(len_q);
  assign rd_phys = (idx_w < IW'(cur_q)) ? AW'(idx_w) : AW'(idx_w + IW'(gap));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (req_q == REQ_READ) begin
          state_d = idx_ok ? ST_RDAT : ST_FIN;
        end else begin
          state_d = exec_move ? ST_STEP : ST_FIN;
        end
      end
      ST_STEP: state_d = step_more ? ST_STEP : ST_FIN;
      ST_RDAT: state_d = ST_FIN;
      ST_FIN: begin
        if (res_take_i) state_d = in_valid_i ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and store access
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_FIN) && res_take_i);
    res_valid_o = (state_q == ST_FIN);
    mem_ctl_o   = '0;
    mem_wdata_o = mem_rdata_i;
    mem_waddr_o = is_back ? AW'(cur_q + gap - 1'b1) : AW'(cur_q);
    rd_base     = (state_q == ST_STEP) ? cur_step : cur_q;
    mem_raddr_o = is_back ? AW'(rd_base - 1'b1) : AW'(rd_base + gap);
    case (state_q)
      ST_EXEC: begin
        if (req_q == REQ_READ) begin
          mem_ctl_o.rd_en = idx_ok;
          mem_raddr_o     = rd_phys;
        end else if (req_q == REQ_INSERT) begin
          mem_ctl_o.wr_en = (len_q < MaxCnt);
          mem_waddr_o     = AW'(cur_q);
          mem_wdata_o     = ch_q;
        end else begin
          mem_ctl_o.rd_en = exec_move;
        end
      end
      ST_STEP: begin
        mem_ctl_o.wr_en = step_move;
        mem_ctl_o.rd_en = step_more;
      end
      default: ;
    endcase
  end

  // Cursor, length and result updates
  always_comb begin
    cur_d   = cur_q;
    len_d   = len_q;
    stat_d  = stat_q;
    rd_d    = rd_q;
    first_d = first_q;
    case (state_q)
      ST_EXEC: begin
        stat_d  = STAT_DONE;
        rd_d    = '0;
        first_d = 1'b1;
        case (req_q)
          REQ_INSERT: begin
            if (len_q < MaxCnt) begin
              cur_d = cur_q + 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              stat_d = STAT_FULL;
            end
          end
          REQ_DELETE: begin
            if (cur_q < len_q) len_d = len_q - 1'b1;
            else stat_d = STAT_NOCHG;
          end
          REQ_READ: begin
            if (!idx_ok) stat_d = STAT_NOCHG;
          end
          default: begin
            if (!exec_move) stat_d = STAT_NOCHG;
          end
        endcase
      end
      ST_STEP: begin
        cur_d   = cur_step;
        first_d = 1'b0;
      end
      ST_RDAT: rd_d = mem_rdata_i;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_type_i);
      ch_q  <= char_in_i;
      idx_q <= read_index_i;
    end
    stat_q  <= stat_d;
    rd_q    <= rd_d;
    first_q <= first_d;
  end

  assign res_status_o = stat_q;
  assign res_cursor_o = cur_q;
  assign res_length_o = len_q;
  assign res_char_o   = rd_q;

`ifndef SYNTH
  a_cur_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond length");

  a_len_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxCnt)
    else $error("length beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.wr_en && mem_ctl_o.rd_en) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write hit the same entry");

  a_step_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_STEP))
    else $error("gap move without a read issued");

  a_len_hold_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |=> $stable(len_q))
    else $error("length changed during a cursor move");
`endif

endmodule

// ===== rtl/text_buffer_with_cursor.sv =====
// Text buffer with cursor, gap buffer in one synchronous memory.
// Insert, delete and requests that change nothing go from the execute state straight
// to the result; reads and single steps pass a read or move state on the way; start,
// end and word begin move n characters, one per cycle (word begin also reads the blank
// it stops at without moving). A new request is taken at the edge its predecessor's
// result is registered. Reset clears only controller state, cursor, length and out valid.
module text_buffer_with_cursor #(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tbc_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tbc_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [tbc_pkg::IDX_W-1:0]     read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tbc_pkg::STAT_W-1:0]    status_o,
  output logic [tbc_pkg::POS_W-1:0]     cursor_pos_o,
  output logic [tbc_pkg::POS_W-1:0]     length_o,
  output logic [tbc_pkg::CHAR_W-1:0]    read_char_o
);
  import tbc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CHARS);
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  logic              res_valid;
  logic              res_take;
  stat_e             res_status;
  logic [CW-1:0]     res_cursor;
  logic [CW-1:0]     res_length;
  logic [CHAR_W-1:0] res_char;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q;
  logic [XW-1:0]     cursor_q;
  logic [XW-1:0]     length_q;
  logic [CHAR_W-1:0] rchar_q;

  tbc_ctrl #(
    .MAX_CHARS (MAX_CHARS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_in_i    (char_in_i),
    .read_index_i (read_index_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_status_o (res_status),
    .res_cursor_o (res_cursor),
    .res_length_o (res_length),
    .res_char_o   (res_char),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tbc_mem #(
    .DEPTH (MAX_CHARS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Take a finished result when the output slot is free or being drained
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res_status;
      cursor_q <= XW'(res_cursor);
      length_q <= XW'(res_length);
      rchar_q  <= res_char;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign cursor_pos_o = cursor_q[POS_W-1:0];
  assign length_o     = length_q[POS_W-1:0];
  assign read_char_o  = rchar_q;

endmodule

// ===== tb/edit_tracker_pkg.sv =====
// Expected-result tracking for the text buffer testbench: a shadow copy of
// the character buffer and cursor, and the queue of results still due.
// Depends on tbc_pkg for request and status codes and field widths.
package edit_tracker_pkg;
  import tbc_pkg::*;

  typedef struct {
    stat_e              status;
    logic [POS_W-1:0]   cursor;
    logic [POS_W-1:0]   length;
    logic [CHAR_W-1:0]  rd;
  } edit_result_t;

  class edit_tracker;
    int unsigned        capacity;
    logic [CHAR_W-1:0]  text_bytes [];
    logic [POS_W-1:0]   cursor;
    logic [POS_W-1:0]   count;
    edit_result_t       expected_q [$];
    int unsigned        error_count;

    function new(int unsigned cap);
      capacity    = cap;
      text_bytes  = new[cap];
      cursor      = '0;
      count       = '0;
      error_count = 0;
    endfunction

    // Tab through carriage return, and space
    function bit blank_char(logic [CHAR_W-1:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    endfunction

    // Update the shadow buffer for one accepted request and queue its result
    function void apply_edit(req_e op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      edit_result_t res;
      int unsigned  k;
      res.status = STAT_DONE;
      res.rd     = '0;
      case (op)
        REQ_FWD: begin
          if (cursor < count) cursor++;
          else res.status = STAT_NOCHG;
        end
        REQ_BACK: begin
          if (cursor != 0) cursor--;
          else res.status = STAT_NOCHG;
        end
        REQ_START: begin
          if (cursor != 0) cursor = '0;
          else res.status = STAT_NOCHG;
        end
        REQ_END: begin
          if (cursor != count) cursor = count;
          else res.status = STAT_NOCHG;
        end
        REQ_INSERT: begin
          if (count >= capacity) begin
            res.status = STAT_FULL;
          end else begin
            for (k = count; k > cursor; k--) text_bytes[k] = text_bytes[k-1];
            text_bytes[cursor] = ch;
            cursor++;
            count++;
          end
        end
        REQ_DELETE: begin
          if (cursor < count) begin
            for (k = cursor; k + 1 < count; k++) text_bytes[k] = text_bytes[k+1];
            count--;
          end else begin
            res.status = STAT_NOCHG;
          end
        end
        REQ_WORD: begin
          if (cursor == 0) begin
            res.status = STAT_NOCHG;
          end else begin
            // Skip one blank right before the cursor, then walk back over the word
            if (blank_char(text_bytes[cursor-1])) cursor--;
            while (cursor != 0 && !blank_char(text_bytes[cursor-1])) cursor--;
          end
        end
        REQ_READ: begin
          if (idx < count) res.rd = text_bytes[idx];
          else res.status = STAT_NOCHG;
        end
        default: ;
      endcase
      res.cursor = cursor;
      res.length = count;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_edit_result(logic [STAT_W-1:0] st, logic [POS_W-1:0] cp,
                                    logic [POS_W-1:0] len, logic [CHAR_W-1:0] rc);
      edit_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d cursor %0d length %0d char %0d",
                 $time, st, cp, len, rc);
        error_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (st !== exp_res.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp_res.status, st);
        error_count++;
      end
      if (cp !== exp_res.cursor) begin
        $display("%0t: cursor_pos expected %0d got %0d", $time, exp_res.cursor, cp);
        error_count++;
      end
      if (len !== exp_res.length) begin
        $display("%0t: length expected %0d got %0d", $time, exp_res.length, len);
        error_count++;
      end
      if (rc !== exp_res.rd) begin
        $display("%0t: read_char expected %0d got %0d", $time, exp_res.rd, rc);
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_text_buffer_with_cursor.sv =====
// Testbench for text_buffer_with_cursor: directed edge cases, then random
// edit requests with random idling on both sides.
// Depends on tbc_pkg and edit_tracker_pkg.
module tb_text_buffer_with_cursor;
  import tbc_pkg::*;
  import edit_tracker_pkg::*;

  localparam int unsigned BUF_CHARS    = 1024;
  localparam int unsigned RANDOM_ITEMS = 725;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned SETTLE_CYCLES = BUF_CHARS + 80;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [CHAR_W-1:0]   char_in_i;
  logic [IDX_W-1:0]    read_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STAT_W-1:0]   status_o;
  logic [POS_W-1:0]    cursor_pos_o;
  logic [POS_W-1:0]    length_o;
  logic [CHAR_W-1:0]   read_char_o;

  edit_tracker         tracker;
  bit                  no_gaps;
  int unsigned         recv_hold;
  int unsigned         cycle_count;

  text_buffer_with_cursor #(
    .MAX_CHARS (BUF_CHARS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_in_i    (char_in_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .cursor_pos_o (cursor_pos_o),
    .length_o     (length_o),
    .read_char_o  (read_char_o)
  );

  // Free-running clock, period 2
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Draw an idle stretch: mostly none or short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Mostly letters, often whitespace, sometimes any byte
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) return ($urandom_range(0, 5) == 5) ? 8'd32 : 8'(9 + $urandom_range(0, 4));
    if (kind == 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_edit(input req_e op, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] ix);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    req_type_i   = op;
    char_in_i    = ch;
    read_index_i = ix;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.apply_edit(op, ch, ix);
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Result side: random stalls plus an occasional long hold
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold != 0) begin
        out_ready_i = 1'b0;
        recv_hold--;
      end else if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_edit_result(status_o, cursor_pos_o, length_o, read_char_o);
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned      i;
    int unsigned      sel;
    int unsigned      ins_w;
    req_e             op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  ix;

    tracker      = new(BUF_CHARS);
    no_gaps      = 1'b0;
    recv_hold    = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_FWD;
    char_in_i    = '0;
    read_index_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every request but insert reports no change on an empty buffer
    send_edit(REQ_FWD,    8'h00, 10'd0);
    send_edit(REQ_BACK,   8'hFF, 10'd0);
    send_edit(REQ_START,  8'h00, 10'd0);
    send_edit(REQ_END,    8'h00, 10'd0);
    send_edit(REQ_DELETE, 8'h00, 10'd0);
    send_edit(REQ_WORD,   8'h00, 10'd0);
    send_edit(REQ_READ,   8'h00, 10'd0);

    // Build text around the whitespace boundaries
    send_edit(REQ_INSERT, 8'h61, 10'd0);
    send_edit(REQ_INSERT, 8'hFF, 10'd0);
    send_edit(REQ_INSERT, 8'd32, 10'd0);
    send_edit(REQ_INSERT, 8'd9,  10'd0);
    send_edit(REQ_INSERT, 8'd13, 10'd0);
    send_edit(REQ_INSERT, 8'h80, 10'd0);
    send_edit(REQ_INSERT, 8'd14, 10'd0);
    send_edit(REQ_INSERT, 8'd8,  10'd0);

    // Word begin over a word, then from right after a blank
    send_edit(REQ_WORD,   8'h00, 10'd0);
    send_edit(REQ_WORD,   8'h00, 10'd0);
    send_edit(REQ_READ,   8'h00, 10'd7);
    send_edit(REQ_READ,   8'h00, 10'd1023);
    send_edit(REQ_BACK,   8'h00, 10'd0);
    send_edit(REQ_FWD,    8'h00, 10'd0);
    send_edit(REQ_END,    8'h00, 10'd0);
    send_edit(REQ_FWD,    8'h00, 10'd0);
    send_edit(REQ_DELETE, 8'h00, 10'd0);
    send_edit(REQ_START,  8'h00, 10'd0);
    send_edit(REQ_DELETE, 8'h00, 10'd0);

    // Random edits with two pressure points
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) recv_hold = 400;
      if (i == 300) wait_for_results();
      no_gaps = (i >= 500 && i < 580);

      // Favor inserts while the text is under 40 characters, then draw far fewer
      sel   = $urandom_range(0, 99);
      ins_w = (tracker.count < 40) ? 35 : 10;
      if (sel < ins_w) begin
        op = REQ_INSERT;
      end else begin
        op = req_e'($urandom_range(0, 6));
        if (op == REQ_INSERT) op = REQ_READ;
      end
      ch = pick_char();
      if (op == REQ_READ && tracker.count != 0 && $urandom_range(0, 1) == 1) begin
        ix = 10'($urandom_range(0, tracker.count - 1));
      end else begin
        ix = 10'($urandom_range(0, 1023));
      end
      send_edit(op, ch, ix);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.expected_q.size());
      tracker.error_count++;
    end
    if (tracker.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== text_buffer_with_cursor.f =====
rtl/tbc_pkg.sv
rtl/tbc_mem.sv
rtl/tbc_ctrl.sv
rtl/text_buffer_with_cursor.sv
tb/edit_tracker_pkg.sv
tb/tb_text_buffer_with_cursor.sv
